// File: hw/rtl/winding_number_point_in_polygon_defines.svh
// Assertion macros for the winding number point-in-polygon block.
// Used by the port checker; no other dependencies.
`ifndef WINDING_NUMBER_POINT_IN_POLYGON_DEFINES_SVH
`define WINDING_NUMBER_POINT_IN_POLYGON_DEFINES_SVH

// same-cycle implication
`define WN_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("wn check failed");

// next-cycle implication
`define WN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("wn check failed");

`endif

// File: hw/rtl/wn_pkg.sv
// Package for the winding number point-in-polygon block.
// Word types and queue constants; no dependencies.
`default_nettype none
package wn_pkg;

  localparam int MidDepth = 4;
  localparam int OutDepth = 4;
  localparam int OutCntW  = $clog2(OutDepth) + 1;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic signed [15:0] query_x;
    logic signed [15:0] query_y;
    logic               first_vertex;
    logic               last_vertex;
  } in_word_t;

  typedef struct packed {
    logic signed [10:0] winding_number;
    logic               inside_res;
  } res_word_t;

  // one edge, reduced to differences and crossing class
  typedef struct packed {
    logic signed [16:0] dnx;
    logic signed [16:0] dqy;
    logic signed [16:0] dqx;
    logic signed [16:0] dny;
    logic               up;
    logic               dn;
  } edge_t;

  typedef struct packed {
    edge_t ea;
    edge_t eb;
    logic  first;
    logic  last;
  } mid_word_t;

endpackage
`default_nettype wire

// File: hw/rtl/wn_fifo.sv
// Small flop-based queue, power-of-two depth.
// Used for the front/back queue and the result queue; no dependencies.
`default_nettype none
module wn_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [Width-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [Width-1:0]           rdata_o,
  output logic                            full_o,
  output logic                            empty_o,
  output logic      [$clog2(Depth):0]     count_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = PtrW + 1;

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign rdata_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(do_push) - CntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/wn_front.sv
// Front end: takes vertex words, holds polygon state, classifies edges.
// Depends on wn_pkg.
`default_nettype none
module wn_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire wn_pkg::in_word_t  in_word_i,
  input  wire logic              mid_full_i,
  output logic                   mid_push_o,
  output wn_pkg::mid_word_t      mid_word_o
);

  logic signed [15:0] start_x_q, start_x_d, start_y_q, start_y_d;
  logic signed [15:0] prior_x_q, prior_y_q;
  logic signed [15:0] hq_x_q, hq_x_d, hq_y_q, hq_y_d;
  logic               accept;

  function automatic wn_pkg::edge_t mk_edge(
    input logic signed [15:0] cx, cy, nx, ny, qx, qy);
    wn_pkg::edge_t e;
    e.dnx = 17'(nx) - 17'(cx);
    e.dqy = 17'(qy) - 17'(cy);
    e.dqx = 17'(qx) - 17'(cx);
    e.dny = 17'(ny) - 17'(cy);
    e.up  = (cy <= qy) && (ny > qy);
    e.dn  = (cy > qy) && (ny <= qy);
    return e;
  endfunction

  assign accept     = push_i && !mid_full_i;
  assign mid_push_o = accept;

  always_comb begin
    wn_pkg::edge_t ea;
    if (in_word_i.first_vertex) begin
      start_x_d = in_word_i.vertex_x;
      start_y_d = in_word_i.vertex_y;
      hq_x_d    = in_word_i.query_x;
      hq_y_d    = in_word_i.query_y;
    end else begin
      start_x_d = start_x_q;
      start_y_d = start_y_q;
      hq_x_d    = hq_x_q;
      hq_y_d    = hq_y_q;
    end
    ea = mk_edge(prior_x_q, prior_y_q, in_word_i.vertex_x, in_word_i.vertex_y,
                 hq_x_d, hq_y_d);
    // no incoming edge on a first vertex
    ea.up = ea.up && !in_word_i.first_vertex;
    ea.dn = ea.dn && !in_word_i.first_vertex;
    mid_word_o.ea    = ea;
    mid_word_o.eb    = mk_edge(in_word_i.vertex_x, in_word_i.vertex_y,
                               start_x_d, start_y_d, hq_x_d, hq_y_d);
    mid_word_o.first = in_word_i.first_vertex;
    mid_word_o.last  = in_word_i.last_vertex;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      prior_x_q <= '0;
      prior_y_q <= '0;
      hq_x_q    <= '0;
      hq_y_q    <= '0;
    end else if (accept) begin
      start_x_q <= start_x_d;
      start_y_q <= start_y_d;
      prior_x_q <= in_word_i.vertex_x;
      prior_y_q <= in_word_i.vertex_y;
      hq_x_q    <= hq_x_d;
      hq_y_q    <= hq_y_d;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/wn_back.sv
// Back end: side products, then the saturating winding count update.
// Depends on wn_pkg.
`default_nettype none
module wn_back #(
  parameter int MaxVertices = 1024
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire wn_pkg::mid_word_t           mid_word_i,
  input  wire logic                        mid_empty_i,
  output logic                             mid_pop_o,
  input  wire logic [wn_pkg::OutCntW-1:0]  out_count_i,
  output logic                             res_push_o,
  output wn_pkg::res_word_t                res_word_o
);

  localparam int WLimHalf = MaxVertices / 2;
  localparam int WLimInt  = (WLimHalf > 1023) ? 1023 : WLimHalf;
  localparam logic signed [10:0] WLim = 11'(WLimInt);
  localparam int UseW = wn_pkg::OutCntW + 1;

  logic               s1_valid_q;
  logic signed [33:0] pa1_q, pa2_q, pb1_q, pb2_q;
  logic               up_a_q, dn_a_q, up_b_q, dn_b_q, first_q, last_q;
  logic signed [10:0] wc_q, wc_d;
  logic [UseW-1:0]    credit_use;
  logic signed [34:0] side_a, side_b;
  logic               inc_a, dec_a, inc_b, dec_b;
  logic signed [10:0] wc0, wc1, wc2;

  function automatic logic signed [10:0] wstep(
    input logic signed [10:0] wc, input logic inc, input logic dec);
    logic signed [10:0] r;
    r = wc;
    if (inc && (wc < WLim)) begin
      r = wc + 11'sd1;
    end else if (dec && (wc > -WLim)) begin
      r = wc - 11'sd1;
    end
    return r;
  endfunction

  // results in flight plus queued must fit the result queue
  assign credit_use = {1'b0, out_count_i} + UseW'(s1_valid_q);
  assign mid_pop_o  = !mid_empty_i && (credit_use < UseW'(wn_pkg::OutDepth));

  always_comb begin
    side_a = 35'(pa1_q) - 35'(pa2_q);
    side_b = 35'(pb1_q) - 35'(pb2_q);
    inc_a  = up_a_q && !side_a[34] && (side_a != '0);
    dec_a  = dn_a_q && side_a[34];
    inc_b  = up_b_q && !side_b[34] && (side_b != '0);
    dec_b  = dn_b_q && side_b[34];
    wc0    = first_q ? 11'sd0 : wc_q;
    wc1    = wstep(wc0, inc_a, dec_a);
    wc2    = last_q ? wstep(wc1, inc_b, dec_b) : wc1;
    wc_d   = s1_valid_q ? wc2 : wc_q;
    res_push_o                = s1_valid_q && last_q;
    res_word_o.winding_number = wc2;
    res_word_o.inside_res     = (wc2 != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wc_q       <= '0;
    end else begin
      s1_valid_q <= mid_pop_o;
      wc_q       <= wc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_pop_o) begin
      pa1_q   <= 34'(mid_word_i.ea.dnx) * 34'(mid_word_i.ea.dqy);
      pa2_q   <= 34'(mid_word_i.ea.dqx) * 34'(mid_word_i.ea.dny);
      pb1_q   <= 34'(mid_word_i.eb.dnx) * 34'(mid_word_i.eb.dqy);
      pb2_q   <= 34'(mid_word_i.eb.dqx) * 34'(mid_word_i.eb.dny);
      up_a_q  <= mid_word_i.ea.up;
      dn_a_q  <= mid_word_i.ea.dn;
      up_b_q  <= mid_word_i.eb.up;
      dn_b_q  <= mid_word_i.eb.dn;
      first_q <= mid_word_i.first;
      last_q  <= mid_word_i.last;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/winding_number_point_in_polygon.sv
// Top level of the streaming winding number point-in-polygon test.
// Depends on wn_pkg, wn_front, wn_fifo and wn_back.
//
// Input channel: one vertex word per push while full is low. The first
// vertex of a polygon carries the query point; the last vertex closes the
// polygon. Result channel: one word per polygon, shown while empty is low,
// taken by pop.
// Throughput: one vertex per cycle while the result queue has room, set by
// the two-stage back end (side products, then the count update) fed from a 4-entry queue.
// Path: a last vertex passes the front/back queue, the side-product registers
// and the result queue before its result shows, when nothing ahead is stalled.
// Stall: the result queue holds 4 words; when it fills the back end stops,
// the front/back queue fills behind it and full rises.
// Reset: all queues empty, polygon state and winding count cleared to zero.
`default_nettype none
module winding_number_point_in_polygon #(
  parameter int MAX_VERTICES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire wn_pkg::in_word_t   in_word_i,
  output logic                    empty,
  input  wire logic               pop,
  output wn_pkg::res_word_t       res_word_o
);

  localparam int MidW = $bits(wn_pkg::mid_word_t);
  localparam int ResW = $bits(wn_pkg::res_word_t);

  wn_pkg::mid_word_t                   mid_wword, mid_rword;
  logic [MidW-1:0]                     mid_rdata;
  logic                                mid_push, mid_pop, mid_full, mid_empty;
  logic [$clog2(wn_pkg::MidDepth):0]   mid_count;
  wn_pkg::res_word_t                   res_wword;
  logic [ResW-1:0]                     res_rdata;
  logic                                res_push, res_full;
  logic [wn_pkg::OutCntW-1:0]          res_count;

  assign full       = mid_full;
  assign mid_rword  = mid_rdata;
  assign res_word_o = res_rdata;

  wn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .in_word_i  (in_word_i),
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .mid_word_o (mid_wword)
  );

  wn_fifo #(
    .Width (MidW),
    .Depth (wn_pkg::MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wword),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  wn_back #(
    .MaxVertices (MAX_VERTICES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_word_i  (mid_rword),
    .mid_empty_i (mid_empty || (mid_count == '0)),
    .mid_pop_o   (mid_pop),
    .out_count_i (res_count),
    .res_push_o  (res_push),
    .res_word_o  (res_wword)
  );

  wn_fifo #(
    .Width (ResW),
    .Depth (wn_pkg::OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wword),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (empty),
    .count_o (res_count)
  );

  // credit logic in the back end keeps pushes off a full result queue
  logic unused_res_full;
  assign unused_res_full = res_full;

endmodule
`default_nettype wire

// File: hw/rtl/wn_checker.sv
// Port-level checker for the winding number block, bound to the top level.
// Depends on wn_pkg and winding_number_point_in_polygon_defines.svh.
`default_nettype none
`include "winding_number_point_in_polygon_defines.svh"
module wn_port_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              push,
  input wire logic              full,
  input wire wn_pkg::in_word_t  in_word_i,
  input wire logic              empty,
  input wire logic              pop,
  input wire wn_pkg::res_word_t res_word_o
);

  logic vertex_seen;
  assign vertex_seen = in_word_i.first_vertex || in_word_i.last_vertex || 1'b1;

  `WN_ASSERT_SAME(a_inside_flag, clk_i, rst_ni, !empty && vertex_seen, res_word_o.inside_res == (res_word_o.winding_number != '0))
  `WN_ASSERT_SAME(a_drain_on_idle, clk_i, rst_ni, $past(empty) && !$past(push), !full)
  `WN_ASSERT_NEXT(a_word_held, clk_i, rst_ni, !empty && !pop, !empty)
  `WN_ASSERT_NEXT(a_word_stable, clk_i, rst_ni, !empty && !pop, $stable(res_word_o))

endmodule

bind winding_number_point_in_polygon wn_port_checker u_wn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .in_word_i  (in_word_i),
  .empty      (empty),
  .pop        (pop),
  .res_word_o (res_word_o)
);
`default_nettype wire
